FILE: src/cha_pkg.sv
`default_nettype none

package cha_pkg;

   localparam int STORE_DEPTH = 256;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int COUNT_W     = 32;
   localparam int SAMPLE_W    = 24;
   localparam int NBINS_W     = 8;
   localparam int HALF_W      = 23;

   localparam logic [NBINS_W-1:0] NBINS_RESET      = 8'd100;
   localparam logic [HALF_W-1:0]  HALF_RANGE_RESET = 23'd327680;

   // operation codes
   localparam logic [1:0] OP_ACCUM = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // register indexes (byte address bit 2)
   localparam logic REG_NBINS      = 1'b0;
   localparam logic REG_HALF_RANGE = 1'b1;

   typedef struct packed {
      logic [1:0]                 opcode;
      logic signed [SAMPLE_W-1:0] sample;
      logic [ADDR_W-1:0]          read_index;
   } cha_req_type;

   typedef struct packed {
      logic               in_range;
      logic [ADDR_W-1:0]  bin_index;
      logic [COUNT_W-1:0] bin_value;
      logic [COUNT_W-1:0] inrange_total;
      logic [COUNT_W-1:0] sample_total;
   } cha_rsp_type;

   typedef struct packed {
      logic              hit;
      logic [ADDR_W-1:0] index;
   } cha_bin_result_type;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      return (v == {COUNT_W{1'b1}}) ? v : v + {{(COUNT_W-1){1'b0}}, 1'b1};
   endfunction

endpackage

`default_nettype wire

FILE: src/cha_bin_ram.sv
`default_nettype none

module cha_bin_ram import cha_pkg::*; (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [ADDR_W-1:0]  wr_addr,
   input  wire logic [COUNT_W-1:0] wr_data,
   input  wire logic               rd_en,
   input  wire logic [ADDR_W-1:0]  rd_addr,
   output logic      [COUNT_W-1:0] rd_data
);

   logic [COUNT_W-1:0] mem [STORE_DEPTH];
   logic [COUNT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: src/cha_binner.sv
`default_nettype none

module cha_binner import cha_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic signed [SAMPLE_W-1:0] sample,
   input  wire logic [NBINS_W-1:0]         nbins,
   input  wire logic [HALF_W-1:0]          half_range,
   output logic                            done,
   output cha_bin_result_type              result
);

   localparam logic [1:0] B_IDLE  = 2'd0;
   localparam logic [1:0] B_CHECK = 2'd1;
   localparam logic [1:0] B_DIV   = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic               done_ff, done_in;
   logic [2:0]         step_ff, step_in;
   logic signed [32:0] prod_ff, prod_in;
   logic [32:0]        off_ff, off_in;
   logic [32:0]        lim_ff, lim_in;
   logic [HALF_W:0]    den_ff, den_in;
   logic               zero_ff, zero_in;
   logic [32:0]        rem_ff, rem_in;
   logic [7:0]         quot_ff, quot_in;
   cha_bin_result_type result_ff, result_in;

   logic signed [33:0] shifted;
   logic [32:0]        den_sh;
   logic               ge;

   // numerator moved up by nbins/2 (rounded down) bins plus half a bin, so the quotient is the bin index itself
   assign shifted = $signed({prod_ff[32], prod_ff}) + $signed({1'b0, off_ff});
   assign den_sh  = 33'(den_ff) << step_ff;
   assign ge      = (rem_ff >= den_sh);

   always_comb begin
      state_in  = state_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      prod_in   = prod_ff;
      off_in    = off_ff;
      lim_in    = lim_ff;
      den_in    = den_ff;
      zero_in   = zero_ff;
      rem_in    = rem_ff;
      quot_in   = quot_ff;
      result_in = result_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (start) begin
               den_in  = {half_range, 1'b0};
               prod_in = $signed({{9{sample[SAMPLE_W-1]}}, sample})
                         * $signed({25'd0, nbins});
               off_in  = 33'(nbins[NBINS_W-1:1]) * 33'({half_range, 1'b0})
                         + 33'(half_range);
               lim_in  = 33'({1'b0, nbins} + 9'd1) * 33'({half_range, 1'b0});
               zero_in = (half_range == '0);
               state_in = B_CHECK;
            end
         end
         B_CHECK: begin
            if (zero_ff || shifted[33] || (shifted[32:0] >= lim_ff)) begin
               result_in.hit   = 1'b0;
               result_in.index = '0;
               done_in  = 1'b1;
               state_in = B_IDLE;
            end else begin
               rem_in   = shifted[32:0];
               quot_in  = '0;
               step_in  = 3'd7;
               state_in = B_DIV;
            end
         end
         B_DIV: begin
            // one quotient bit per cycle, most significant first
            if (ge) begin
               rem_in = rem_ff - den_sh;
            end
            quot_in = {quot_ff[6:0], ge};
            step_in = step_ff - 3'd1;
            if (step_ff == 3'd0) begin
               result_in.hit   = 1'b1;
               result_in.index = {quot_ff[6:0], ge};
               done_in  = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         done_ff  <= 1'b0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      off_ff    <= off_in;
      lim_ff    <= lim_in;
      den_ff    <= den_in;
      zero_ff   <= zero_in;
      rem_ff    <= rem_in;
      quot_ff   <= quot_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

`default_nettype wire

FILE: src/centered_histogram_accumulator.sv
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  cha_req_type: opcode, sample, read_index
// rsp_      out        rsp_valid/rsp_stall  cha_rsp_type: in_range, bin_index, bin_value,
//                                           inrange_total, sample_total
// csr_      in         APB, pready high     nbins at 0x0, half_range at 0x4
//
// One item at a time. An in-range sample passes the range check and the bit-serial
// quotient loop, then a bin read and write back; an out-of-range sample stops after
// the range check; a read fetches one bin, a clear zeroes all bins.
// After reset a pass over all 256 bins zeroes the bin memory; no item is taken meanwhile.
// A held result sits in the output register; the next item is still taken and
// waits for that register before its own result is loaded.
`default_nettype none

module centered_histogram_accumulator import cha_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire cha_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output cha_rsp_type      rsp_data,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_BIN    = 3'd2;
   localparam logic [2:0] S_RMW    = 3'd3;
   localparam logic [2:0] S_READ   = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

   logic [2:0]         state_ff, state_in;
   logic [NBINS_W-1:0] nbins_ff, nbins_in;
   logic [HALF_W-1:0]  half_range_ff, half_range_in;
   logic [COUNT_W-1:0] sample_total_ff, sample_total_in;
   logic [COUNT_W-1:0] inrange_total_ff, inrange_total_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic               clr_rsp_ff, clr_rsp_in;
   logic [ADDR_W-1:0]  bin_idx_ff, bin_idx_in;
   cha_rsp_type        res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   cha_rsp_type        rsp_data_ff, rsp_data_in;

   logic               csr_wr;
   logic               bin_start;
   logic               bin_done;
   cha_bin_result_type bin_res;
   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [COUNT_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [COUNT_W-1:0] ram_rd_data;
   logic [COUNT_W-1:0] bin_new;
   logic               rsp_load;

   cha_binner u_binner (
      .clock      (clock),
      .reset      (reset),
      .start      (bin_start),
      .sample     (req_data.sample),
      .nbins      (nbins_ff),
      .half_range (half_range_ff),
      .done       (bin_done),
      .result     (bin_res)
   );

   cha_bin_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_HALF_RANGE) ? 32'(half_range_ff)
                                                        : 32'(nbins_ff);

   assign req_stall = (state_ff != S_IDLE);
   assign bin_new   = sat_inc(ram_rd_data);

   always_comb begin
      nbins_in      = nbins_ff;
      half_range_in = half_range_ff;
      if (csr_wr) begin
         if (csr_paddr[2] == REG_HALF_RANGE) begin
            half_range_in = csr_pwdata[HALF_W-1:0];
         end else begin
            nbins_in = csr_pwdata[NBINS_W-1:0];
         end
      end
   end

   always_comb begin
      state_in         = state_ff;
      sample_total_in  = sample_total_ff;
      inrange_total_in = inrange_total_ff;
      clr_addr_in      = clr_addr_ff;
      clr_rsp_in       = clr_rsp_ff;
      bin_idx_in       = bin_idx_ff;
      res_in           = res_ff;
      rsp_data_in      = rsp_data_ff;
      rsp_load         = 1'b0;
      bin_start        = 1'b0;
      ram_wr_en        = 1'b0;
      ram_wr_addr      = clr_addr_ff;
      ram_wr_data      = '0;
      ram_rd_en        = 1'b0;
      ram_rd_addr      = req_data.read_index;
      unique case (state_ff)
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == LAST_ADDR) begin
               if (clr_rsp_ff) begin
                  res_in   = '0;
                  state_in = S_FINISH;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_data.opcode)
                  OP_ACCUM: begin
                     bin_start = 1'b1;
                     state_in  = S_BIN;
                  end
                  OP_READ: begin
                     ram_rd_en  = 1'b1;
                     bin_idx_in = req_data.read_index;
                     state_in   = S_READ;
                  end
                  OP_CLEAR: begin
                     clr_addr_in      = '0;
                     clr_rsp_in       = 1'b1;
                     sample_total_in  = '0;
                     inrange_total_in = '0;
                     state_in         = S_CLEAR;
                  end
                  default: begin
                     res_in.in_range      = 1'b0;
                     res_in.bin_index     = '0;
                     res_in.bin_value     = '0;
                     res_in.inrange_total = inrange_total_ff;
                     res_in.sample_total  = sample_total_ff;
                     state_in             = S_FINISH;
                  end
               endcase
            end
         end
         S_BIN: begin
            if (bin_done) begin
               if (bin_res.hit) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = bin_res.index;
                  bin_idx_in  = bin_res.index;
                  state_in    = S_RMW;
               end else begin
                  sample_total_in      = sat_inc(sample_total_ff);
                  res_in.in_range      = 1'b0;
                  res_in.bin_index     = '0;
                  res_in.bin_value     = '0;
                  res_in.inrange_total = inrange_total_ff;
                  res_in.sample_total  = sat_inc(sample_total_ff);
                  state_in             = S_FINISH;
               end
            end
         end
         S_RMW: begin
            // only one item is in flight, so the read data is never stale
            ram_wr_en            = 1'b1;
            ram_wr_addr          = bin_idx_ff;
            ram_wr_data          = bin_new;
            inrange_total_in     = sat_inc(inrange_total_ff);
            sample_total_in      = sat_inc(sample_total_ff);
            res_in.in_range      = 1'b1;
            res_in.bin_index     = bin_idx_ff;
            res_in.bin_value     = bin_new;
            res_in.inrange_total = sat_inc(inrange_total_ff);
            res_in.sample_total  = sat_inc(sample_total_ff);
            state_in             = S_FINISH;
         end
         S_READ: begin
            res_in.in_range      = 1'b0;
            res_in.bin_index     = bin_idx_ff;
            res_in.bin_value     = ram_rd_data;
            res_in.inrange_total = inrange_total_ff;
            res_in.sample_total  = sample_total_ff;
            state_in             = S_FINISH;
         end
         S_FINISH: begin
            // hold until the output register is free or being drained
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load    = 1'b1;
               rsp_data_in = res_ff;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_CLEAR;
         nbins_ff         <= NBINS_RESET;
         half_range_ff    <= HALF_RANGE_RESET;
         sample_total_ff  <= '0;
         inrange_total_ff <= '0;
         clr_addr_ff      <= '0;
         clr_rsp_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         nbins_ff         <= nbins_in;
         half_range_ff    <= half_range_in;
         sample_total_ff  <= sample_total_in;
         inrange_total_ff <= inrange_total_in;
         clr_addr_ff      <= clr_addr_in;
         clr_rsp_ff       <= clr_rsp_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_idx_ff  <= bin_idx_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: src/cha_checker.sv
`default_nettype none

module cha_checker import cha_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire cha_rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // one item in flight: the input is always closed in the cycle after a transfer
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken while one is in progress");

   a_hit_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_data.in_range
                    || (rsp_data.bin_value != '0 && rsp_data.inrange_total != '0))
      else $error("in-range result with an empty count");

   a_totals: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.sample_total >= rsp_data.inrange_total)
      else $error("in-range total exceeds sample total");

   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !rsp_valid && req_stall)
      else $error("activity straight after reset");

endmodule

bind centered_histogram_accumulator cha_checker u_cha_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
